>>> rtl/core/rrip_pkg.sv
// Shared constants, row layout and controller/datapath interface types for the RRIP block.
package rrip_pkg;

  localparam int SETS        = 2048;
  localparam int SET_W       = $clog2(SETS);
  localparam int WAYS        = 16;
  localparam int WAY_W       = $clog2(WAYS);
  localparam int SIG_DEPTH   = 1024;
  localparam int SIG_W       = $clog2(SIG_DEPTH);
  localparam int HISTORY     = 4;
  localparam int HIST_W      = $clog2(HISTORY);
  localparam int RRPV_W      = 2;
  localparam int REUSE_W     = 2;
  localparam int CTR_W       = 4;
  localparam int ADDR_W      = 48;
  localparam int DELTA_W     = ADDR_W + 1;

  localparam logic [RRPV_W-1:0]  RRPV_DISTANT = {RRPV_W{1'b1}};
  localparam logic [REUSE_W-1:0] REUSE_SAT    = {REUSE_W{1'b1}};
  localparam logic [CTR_W-1:0]   CTR_MAX      = 4'd15;
  localparam logic [CTR_W-1:0]   CTR_RESET    = 4'd8;
  localparam logic [CTR_W-1:0]   THRESH_RESET = 4'd12;

  // kind codes
  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // one row per set: line state plus the stream detector
  typedef struct packed {
    logic [WAYS-1:0][RRPV_W-1:0]     rrpv;
    logic [WAYS-1:0][REUSE_W-1:0]    reuse;
    logic [WAYS-1:0][SIG_W-1:0]      sig;
    logic [ADDR_W-1:0]               prev_addr;
    logic [HISTORY-1:0][DELTA_W-1:0] hist;
    logic [HIST_W-1:0]               ptr;
    logic                            stream;
  } set_row_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic exec;
    logic decay;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_decay;
  } dp_sts_t;

endpackage

>>> rtl/core/rrip_dp.sv
// Datapath: set row memory, signature counter memory, victim select and update logic.
module rrip_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_kind,
  input  logic [rrip_pkg::SET_W-1:0]  in_set_index,
  input  logic [rrip_pkg::WAY_W-1:0]  in_way,
  input  logic [rrip_pkg::ADDR_W-1:0] in_address,
  input  logic [rrip_pkg::ADDR_W-1:0] in_pc,
  input  logic                        in_hit,
  input  logic                        in_victim_valid,
  input  logic                        cfg_we,
  input  logic [rrip_pkg::CTR_W-1:0]  cfg_data,
  input  rrip_pkg::dp_cmd_t           cmd,
  output rrip_pkg::dp_sts_t           sts,
  output logic [rrip_pkg::WAY_W-1:0]  out_victim_way,
  output logic                        out_set_streaming,
  output logic                        out_fill_skipped
);
  import rrip_pkg::*;

  set_row_t          row_mem [SETS];
  logic [CTR_W-1:0]  ctr_mem [SIG_DEPTH];

  logic              kind_r, hit_r, vv_r;
  logic [SET_W-1:0]  set_r;
  logic [WAY_W-1:0]  way_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIG_W-1:0]  sig_r;
  logic [SIG_W-1:0]  old_sig_r;
  set_row_t          row_q;
  logic [CTR_W-1:0]  ctr_q;
  logic [CTR_W-1:0]  thr_r;
  logic [SET_W-1:0]  clr_cnt_r;
  logic [WAY_W-1:0]  res_way_r;
  logic              res_str_r, res_skip_r;

  // input capture, signature hash taken here
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      set_r  <= in_set_index;
      way_r  <= in_way;
      addr_r <= in_address;
      sig_r  <= in_pc[SIG_W+1:2] ^ in_pc[SIG_W+7:8];
      hit_r  <= in_hit;
      vv_r   <= in_victim_valid;
    end
  end

  // threshold register and clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESH_RESET;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == SET_W'(SETS - 1));

  // victim select: streaming pick, else age to the max and pick lowest at it
  logic [RRPV_W-1:0] max_rrpv, age;
  logic              str_found;
  logic [WAY_W-1:0]  str_way, rr_way;
  set_row_t          vic_row;

  always_comb begin
    max_rrpv  = '0;
    str_found = 1'b0;
    str_way   = '0;
    rr_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_q.rrpv[w] > max_rrpv) max_rrpv = row_q.rrpv[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_q.reuse[w] == '0) begin
        str_found = 1'b1;
        str_way   = WAY_W'(w);
      end
      if (row_q.rrpv[w] == max_rrpv) rr_way = WAY_W'(w);
    end
    age     = RRPV_DISTANT - max_rrpv;
    vic_row = row_q;
    if (!(row_q.stream && str_found)) begin
      for (int w = 0; w < WAYS; w++) vic_row.rrpv[w] = row_q.rrpv[w] + age;
    end
  end

  // update: stream detector, hit/miss line update
  logic [DELTA_W-1:0] delta;
  logic               all_eq, str_new, skip;
  logic [REUSE_W-1:0] reuse_dec;
  logic [RRPV_W-1:0]  ins, old_rrpv;
  set_row_t           upd_row;

  always_comb begin
    upd_row = row_q;
    delta   = '0;
    if (row_q.prev_addr != '0) delta = {1'b0, addr_r} - {1'b0, row_q.prev_addr};
    upd_row.prev_addr          = addr_r;
    upd_row.hist[row_q.ptr]    = delta;
    upd_row.ptr                = row_q.ptr + 1'b1;
    all_eq = 1'b1;
    for (int i = 1; i < HISTORY; i++) begin
      if (upd_row.hist[i] != upd_row.hist[0]) all_eq = 1'b0;
    end
    str_new        = all_eq && (upd_row.hist[0] != '0);
    upd_row.stream = str_new;
    reuse_dec = (row_q.reuse[way_r] != '0) ? row_q.reuse[way_r] - 1'b1 : '0;
    skip      = 1'b0;
    old_rrpv  = row_q.rrpv[way_r];
    ins       = (ctr_q >= thr_r) ? RRPV_DISTANT - 1'b1 : RRPV_DISTANT;
    if (str_new) ins = RRPV_DISTANT;
    if (hit_r) begin
      upd_row.rrpv[way_r] = '0;
      if (row_q.reuse[way_r] != REUSE_SAT) upd_row.reuse[way_r] = row_q.reuse[way_r] + 1'b1;
    end else if (str_new && reuse_dec == '0) begin
      skip                 = 1'b1;
      upd_row.reuse[way_r] = reuse_dec;
    end else begin
      upd_row.rrpv[way_r]  = ins;
      upd_row.sig[way_r]   = sig_r;
      upd_row.reuse[way_r] = '0;
    end
  end

  assign sts.need_decay = (kind_r == KIND_UPDATE) && !hit_r && !skip && vv_r
                          && (old_rrpv == RRPV_DISTANT);

  // set row memory: one write port, registered read
  set_row_t         row_wd;
  logic             row_we;
  logic [SET_W-1:0] row_wa;

  always_comb begin
    row_wd = '0;
    for (int w = 0; w < WAYS; w++) row_wd.rrpv[w] = RRPV_DISTANT;
    row_we = cmd.clear || cmd.exec;
    row_wa = cmd.clear ? clr_cnt_r : set_r;
    if (cmd.exec) row_wd = (kind_r == KIND_UPDATE) ? upd_row : vic_row;
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (cmd.read) row_q <= row_mem[set_r];
  end

  // signature counter memory: one write port, registered read
  logic [CTR_W-1:0] ctr_wd;
  logic [SIG_W-1:0] ctr_wa, ctr_ra;
  logic             ctr_we;

  always_comb begin
    ctr_we = 1'b0;
    ctr_wa = sig_r;
    ctr_wd = ctr_q;
    ctr_ra = cmd.exec ? row_q.sig[way_r] : sig_r;
    if (cmd.clear) begin
      ctr_we = 1'b1;
      ctr_wa = clr_cnt_r[SIG_W-1:0];
      ctr_wd = CTR_RESET;
    end else if (cmd.exec && kind_r == KIND_UPDATE && hit_r) begin
      ctr_we = 1'b1;
      ctr_wd = (ctr_q != CTR_MAX) ? ctr_q + 1'b1 : ctr_q;
    end else if (cmd.decay) begin
      ctr_we = 1'b1;
      ctr_wa = old_sig_r;
      ctr_wd = (ctr_q != '0) ? ctr_q - 1'b1 : ctr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    if (cmd.read || cmd.exec) ctr_q <= ctr_mem[ctr_ra];
  end

  // result staging and output word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      old_sig_r <= row_q.sig[way_r];
      if (kind_r == KIND_UPDATE) begin
        res_way_r  <= '0;
        res_str_r  <= str_new;
        res_skip_r <= skip;
      end else begin
        res_way_r  <= (row_q.stream && str_found) ? str_way : rr_way;
        res_str_r  <= row_q.stream;
        res_skip_r <= 1'b0;
      end
    end
    if (cmd.load_out) begin
      out_victim_way    <= res_way_r;
      out_set_streaming <= res_str_r;
      out_fill_skipped  <= res_skip_r;
    end
  end

endmodule

>>> rtl/core/rrip_ctrl.sv
// Controller: sequences clear sweep, read, execute, decay and output load.
module rrip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rrip_pkg::dp_sts_t sts,
  output rrip_pkg::dp_cmd_t cmd
);
  import rrip_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DECAY, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_decay ? ST_DECAY : ST_DONE;
      end
      ST_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/rrip_replacement_with_stream_bypass.sv
// Top level: RRIP replacement policy with per-set stream bypass.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid/in_ready, kind..victim_valid          | in
//  out     | out_valid/out_ready, victim_way..fill_skipped  | out
//  cfg     | cfg_valid/cfg_ready, cfg_data (threshold)      | in
//
// One word at a time: accept, row read, execute, optional counter decay when an
// evicted line decays its counter, and output load; the next word is accepted only
// after the output load. After reset a clearing pass writes every set row and counter;
// no word is accepted during it. A waiting output word holds the next one in
// its last step only; config writes are always taken.
module rrip_replacement_with_stream_bypass (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [rrip_pkg::SET_W-1:0]  in_set_index,
  input  logic [rrip_pkg::WAY_W-1:0]  in_way,
  input  logic [rrip_pkg::ADDR_W-1:0] in_address,
  input  logic [rrip_pkg::ADDR_W-1:0] in_pc,
  input  logic                        in_hit,
  input  logic                        in_victim_valid,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrip_pkg::WAY_W-1:0]  out_victim_way,
  output logic                        out_set_streaming,
  output logic                        out_fill_skipped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rrip_pkg::CTR_W-1:0]  cfg_data
);
  import rrip_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rrip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrip_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_set_index      (in_set_index),
    .in_way            (in_way),
    .in_address        (in_address),
    .in_pc             (in_pc),
    .in_hit            (in_hit),
    .in_victim_valid   (in_victim_valid),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_victim_way    (out_victim_way),
    .out_set_streaming (out_set_streaming),
    .out_fill_skipped  (out_fill_skipped)
  );

endmodule
